// ===== rtl/crsf_pkg.sv =====
// ----------------------------------------------------------------------------
// crsf_pkg
// Shared word types, register indexes, result kinds and the CRC-8 byte step.
// ----------------------------------------------------------------------------
`default_nettype none

package crsf_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       frame_end;
        logic       link_went_up;
        logic       last;
    } out_word_t;

    // Requests from the sequencer to the output staging
    typedef struct packed {
        logic push;
        logic finish;
    } ost_ctrl_t;

    localparam logic [1:0] KIND_OOB       = 2'd0;
    localparam logic [1:0] KIND_FRAME     = 2'd1;
    localparam logic [1:0] KIND_LINK_DOWN = 2'd2;

    localparam logic [2:0] REG_PASSTHROUGH = 3'd0;
    localparam logic [2:0] REG_MAX_PAYLOAD = 3'd1;
    localparam logic [2:0] REG_TIMEOUT     = 3'd2;
    localparam logic [2:0] REG_FAILSAFE    = 3'd3;
    localparam logic [2:0] REG_ADDR_CTRL   = 3'd4;
    localparam logic [2:0] REG_ADDR_TX     = 3'd5;
    localparam logic [2:0] REG_CHAN_TYPE   = 3'd6;

    localparam logic       OP_BYTE        = 1'b0;
    localparam logic [7:0] CRC_POLY       = 8'hD5;
    localparam logic [9:0] MIN_FRAME_SIZE = 10'd3;

    // One byte of CRC-8, MSB first; the byte is already XORed in
    function automatic logic [7:0] crc8_step(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/crsf_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// crsf_frame_receiver
// Deframes received bytes with a circular window store, CRC-8 check, frame
// forwarding, idle flush and link failsafe.
// ----------------------------------------------------------------------------
//  channel   signals                          accepted when
//  in        in_valid in_ready in_data        in_valid && in_ready
//  out       out_valid out_ready out_data     out_valid && out_ready
//  cfg       cfg_we cfg_index cfg_wdata       cfg_we
//
//  One item at a time; every window access goes through the single
//  registered read port, and output stalls can hold any item.
//  Reset empties the window and lowers the link; the store itself is not
//  cleared. Results wait in a one-word stage plus the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_frame_receiver #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire crsf_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output crsf_pkg::out_word_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata
);
    import crsf_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int CW = 10;
    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_SIZE = 4'd2;
    localparam logic [3:0] S_SHRD = 4'd3;
    localparam logic [3:0] S_SHUS = 4'd4;
    localparam logic [3:0] S_CRRD = 4'd5;
    localparam logic [3:0] S_CRUS = 4'd6;
    localparam logic [3:0] S_CHK  = 4'd7;
    localparam logic [3:0] S_FWRD = 4'd8;
    localparam logic [3:0] S_FWUS = 4'd9;
    localparam logic [3:0] S_ENDB = 4'd10;
    localparam logic [3:0] S_FLRD = 4'd11;
    localparam logic [3:0] S_FLUS = 4'd12;
    localparam logic [3:0] S_FAIL = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    // configuration
    logic        pass_reg;
    logic [5:0]  maxp_reg;
    logic [15:0] tmo_reg;
    logic [15:0] fs_reg;
    logic [7:0]  addr_c_reg;
    logic [7:0]  addr_t_reg;
    logic [7:0]  chan_reg;

    // control state
    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [15:0]   idle_reg, idle_next;
    logic [15:0]   since_reg, since_next;
    logic          link_reg, link_next;
    logic          from_flush_reg, from_flush_next;
    logic [7:0]    size_reg, size_next;
    logic [FW-1:0] j_reg, j_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    type_reg, type_next;

    // store and output staging
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;
    ost_ctrl_t     ost;
    out_word_t     push_word;
    logic          can_push;
    logic          held;

    logic [CW-1:0] fill_w;
    logic [CW-1:0] size_w;
    logic [CW-1:0] j_w;
    logic [CW-1:0] total_w;
    logic          chan_hit;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, h} + {1'b0, off};
        if (s >= {1'b0, DEPTH_C})
        begin
            s = s - {1'b0, DEPTH_C};
        end
        return s[AW-1:0];
    endfunction

    assign fill_w  = CW'(fill_reg);
    assign size_w  = {2'b00, size_reg};
    assign j_w     = CW'(j_reg);
    assign total_w = size_w + 10'd2;
    assign chan_hit = (addr_reg == addr_c_reg || addr_reg == addr_t_reg)
                      && type_reg == chan_reg;
    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg   <= 1'b0;
            maxp_reg   <= 6'd60;
            tmo_reg    <= 16'd100;
            fs_reg     <= 16'd300;
            addr_c_reg <= 8'd200;
            addr_t_reg <= 8'd238;
            chan_reg   <= 8'd22;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PASSTHROUGH: pass_reg   <= cfg_wdata[0];
                REG_MAX_PAYLOAD: maxp_reg   <= cfg_wdata[5:0];
                REG_TIMEOUT:     tmo_reg    <= cfg_wdata;
                REG_FAILSAFE:    fs_reg     <= cfg_wdata;
                REG_ADDR_CTRL:   addr_c_reg <= cfg_wdata[7:0];
                REG_ADDR_TX:     addr_t_reg <= cfg_wdata[7:0];
                REG_CHAN_TYPE:   chan_reg   <= cfg_wdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        idle_next       = idle_reg;
        since_next      = since_reg;
        link_next       = link_reg;
        from_flush_next = from_flush_reg;
        size_next       = size_reg;
        j_next          = j_reg;
        crc_next        = crc_reg;
        addr_next       = addr_reg;
        type_next       = type_reg;
        mem_we          = 1'b0;
        mem_waddr       = phys(head_reg, fill_w);
        mem_wdata       = in_data.rx_byte;
        mem_raddr       = head_reg;
        ost             = '0;
        push_word       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == OP_BYTE)
                    begin
                        idle_next = 16'd0;
                        if (pass_reg)
                        begin
                            ost.push       = 1'b1;
                            push_word.kind = KIND_OOB;
                            push_word.data = in_data.rx_byte;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            fill_next  = fill_reg + 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (idle_reg != 16'hFFFF)
                        begin
                            idle_next = idle_reg + 16'd1;
                        end
                        if (since_reg != 16'hFFFF)
                        begin
                            since_next = since_reg + 16'd1;
                        end
                        from_flush_next = 1'b1;
                        if (fill_reg != '0 && idle_next > tmo_reg)
                        begin
                            state_next = S_FLRD;
                        end
                        else
                        begin
                            state_next = S_FAIL;
                        end
                    end
                end
                // a passthrough word leaves via the stage; hold if it is busy
                if (ost.push && !can_push)
                begin
                    state_next = S_IDLE;
                    idle_next  = idle_reg;
                    ost.push   = 1'b0;
                end
            end

            S_SCAN:
            begin
                from_flush_next = 1'b0;
                if (fill_w <= 10'd1)
                begin
                    state_next = S_ENDB;
                end
                else
                begin
                    mem_raddr  = phys(head_reg, 10'd1);
                    state_next = S_SIZE;
                end
            end

            S_SIZE:
            begin
                size_next = mem_rdata;
                if ({2'b00, mem_rdata} < MIN_FRAME_SIZE
                    || {2'b00, mem_rdata} > {4'b0000, maxp_reg} + 10'd2)
                begin
                    state_next = S_SHRD;
                end
                else if (fill_w >= {2'b00, mem_rdata} + 10'd2)
                begin
                    j_next     = FW'(2);
                    crc_next   = 8'd0;
                    state_next = S_CRRD;
                end
                else
                begin
                    state_next = S_ENDB;
                end
            end

            // drop the oldest byte, emitting it
            S_SHRD:
            begin
                mem_raddr  = head_reg;
                state_next = S_SHUS;
            end

            S_SHUS:
            begin
                mem_raddr = head_reg;
                ost.push       = 1'b1;
                push_word.kind = KIND_OOB;
                push_word.data = mem_rdata;
                if (can_push)
                begin
                    head_next  = phys(head_reg, 10'd1);
                    fill_next  = fill_reg - 1'b1;
                    state_next = from_flush_reg ? S_FLRD : S_SCAN;
                end
            end

            S_CRRD:
            begin
                mem_raddr  = phys(head_reg, j_w);
                state_next = (j_w == size_w + 10'd1) ? S_CHK : S_CRUS;
            end

            S_CRUS:
            begin
                crc_next   = crc8_step(crc_reg ^ mem_rdata);
                j_next     = j_reg + 1'b1;
                state_next = S_CRRD;
            end

            S_CHK:
            begin
                if (crc_reg == mem_rdata)
                begin
                    j_next     = '0;
                    state_next = S_FWRD;
                end
                else
                begin
                    state_next = S_SHRD;
                end
            end

            S_FWRD:
            begin
                mem_raddr  = phys(head_reg, j_w);
                state_next = S_FWUS;
            end

            S_FWUS:
            begin
                mem_raddr      = phys(head_reg, j_w);
                ost.push       = 1'b1;
                push_word.kind = KIND_FRAME;
                push_word.data = mem_rdata;
                if (j_w + 10'd1 == total_w)
                begin
                    push_word.frame_end    = 1'b1;
                    push_word.link_went_up = chan_hit && !link_reg;
                end
                if (can_push)
                begin
                    if (j_w == 10'd0)
                    begin
                        addr_next = mem_rdata;
                    end
                    if (j_w == 10'd2)
                    begin
                        type_next = mem_rdata;
                    end
                    if (j_w + 10'd1 == total_w)
                    begin
                        if (chan_hit)
                        begin
                            link_next  = 1'b1;
                            since_next = 16'd0;
                        end
                        head_next  = phys(head_reg, total_w);
                        fill_next  = FW'(fill_w - total_w);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_FWRD;
                    end
                end
            end

            S_ENDB:
            begin
                if (fill_w >= DEPTH_C)
                begin
                    fill_next = '0;
                end
                state_next = S_DONE;
            end

            // flush the window a byte at a time; the final byte just goes
            S_FLRD:
            begin
                if (fill_reg == '0)
                begin
                    state_next = S_FAIL;
                end
                else if (fill_w == 10'd1)
                begin
                    fill_next  = '0;
                    state_next = S_FAIL;
                end
                else
                begin
                    mem_raddr  = head_reg;
                    state_next = S_SHUS;
                end
            end

            S_FAIL:
            begin
                if (link_reg && since_reg > fs_reg)
                begin
                    ost.push       = 1'b1;
                    push_word.kind = KIND_LINK_DOWN;
                    if (can_push)
                    begin
                        link_next  = 1'b0;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                ost.finish = 1'b1;
                if (!held)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            idle_reg       <= '0;
            since_reg      <= '0;
            link_reg       <= 1'b0;
            from_flush_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            idle_reg       <= idle_next;
            since_reg      <= since_next;
            link_reg       <= link_next;
            from_flush_reg <= from_flush_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        j_reg    <= j_next;
        crc_reg  <= crc_next;
        addr_reg <= addr_next;
        type_reg <= type_next;
    end

    crsf_window_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    crsf_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ost),
        .push_word (push_word),
        .can_push  (can_push),
        .held      (held),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/crsf_window_ram.sv =====
// ----------------------------------------------------------------------------
// crsf_window_ram
// Byte store of the frame window: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_window_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/crsf_out_stage.sv =====
// ----------------------------------------------------------------------------
// crsf_out_stage
// Holds one result back so the last one of an item can be marked, then
// drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crsf_pkg::ost_ctrl_t ctrl,
    input  wire crsf_pkg::out_word_t push_word,
    output logic                     can_push,
    output logic                     held,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output crsf_pkg::out_word_t      out_data
);
    import crsf_pkg::*;

    logic      st_valid_reg;
    out_word_t st_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    out_word_t move_word;
    logic      out_free;
    logic      move;

    assign out_free  = !out_valid_reg || out_ready;
    assign move      = st_valid_reg && (ctrl.push || ctrl.finish) && out_free;
    assign can_push  = !st_valid_reg || out_free;
    assign held      = st_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    // mark the held word as last when the item finishes
    always_comb
    begin
        move_word      = st_word_reg;
        move_word.last = ctrl.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.push && can_push)
            begin
                st_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                st_valid_reg <= 1'b0;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && can_push)
        begin
            st_word_reg <= push_word;
        end
        if (move)
        begin
            out_word_reg <= move_word;
        end
    end

endmodule

`default_nettype wire

// ===== tb/crsf_frame_receiver_test.sv =====
// ----------------------------------------------------------------------------
// crsf_frame_receiver_test
// Drives received bytes and millisecond ticks through the deframer under
// random stalls on both channels, predicts every result word from a model of
// the window, CRC check, idle flush and failsafe, and checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module crsf_frame_receiver_test;
    import crsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 20000;
    localparam logic OP_TICK   = 1'b1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_word_t in_data;
    logic out_valid;
    logic out_ready;
    out_word_t out_data;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [15:0] cfg_wdata;

    crsf_frame_receiver #(.WINDOW_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    // model state and registers
    logic        m_pass;
    logic [5:0]  m_maxpl;
    logic [15:0] m_timeout;
    logic [15:0] m_failsafe;
    logic [7:0]  m_addr_fc;
    logic [7:0]  m_addr_tx;
    logic [7:0]  m_chtype;
    logic [7:0]  win [DEPTH];
    int          fill;
    logic [15:0] idle_ms;
    logic [15:0] since_ch;
    logic        link_up;

    out_word_t expected_words[$];
    out_word_t pending[$];
    int  errors;
    int  quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic out_word_t mk(logic [1:0] k, logic [7:0] d, logic fe, logic up);
        out_word_t w;
        w.kind = k;
        w.data = d;
        w.frame_end = fe;
        w.link_went_up = up;
        w.last = 1'b0;
        return w;
    endfunction

    function automatic logic [7:0] crc_of(int start, int count);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < count; i++)
        begin
            c ^= (start + i < DEPTH) ? win[start + i] : 8'h00;
            for (int b = 0; b < 8; b++)
            begin
                c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
            end
        end
        return c;
    endfunction

    task automatic shift_window();
        if (fill <= 1)
        begin
            fill = 0;
            return;
        end
        pending.push_back(mk(KIND_OOB, win[0], 1'b0, 1'b0));
        for (int i = 0; i < fill - 1; i++) win[i] = win[i + 1];
        fill--;
    endtask

    task automatic forward_frame(int size);
        int  total;
        logic up;
        total = size + 2;
        up = 1'b0;
        if ((win[0] == m_addr_fc || win[0] == m_addr_tx) && win[2] == m_chtype)
        begin
            up = !link_up;
            link_up = 1'b1;
            since_ch = 16'd0;
        end
        for (int i = 0; i < total; i++)
        begin
            pending.push_back(mk(KIND_FRAME, win[i], i + 1 == total,
                                 (i + 1 == total) ? up : 1'b0));
        end
        for (int i = 0; i < fill - total; i++) win[i] = win[i + total];
        fill = (total >= fill) ? 0 : fill - total;
    endtask

    task automatic predict_word(in_word_t w);
        int size;
        pending.delete();
        if (w.op == OP_BYTE)
        begin
            idle_ms = 16'd0;
            if (m_pass)
            begin
                pending.push_back(mk(KIND_OOB, w.rx_byte, 1'b0, 1'b0));
            end
            else
            begin
                if (fill < DEPTH) win[fill++] = w.rx_byte;
                while (fill > 1)
                begin
                    size = win[1];
                    if (size < 3 || size > m_maxpl + 2)
                        shift_window();
                    else if (fill >= size + 2)
                    begin
                        if (crc_of(2, size - 1) == win[size + 1])
                            forward_frame(size);
                        else
                            shift_window();
                    end
                    else
                        break;
                end
                if (fill >= DEPTH) fill = 0;
            end
        end
        else
        begin
            if (idle_ms != 16'hFFFF) idle_ms++;
            if (since_ch != 16'hFFFF) since_ch++;
            if (fill > 0 && idle_ms > m_timeout)
                while (fill > 0) shift_window();
            if (link_up && since_ch > m_failsafe)
            begin
                pending.push_back(mk(KIND_LINK_DOWN, 8'h00, 1'b0, 1'b0));
                link_up = 1'b0;
            end
        end
        if (pending.size() > 0) pending[pending.size() - 1].last = 1'b1;
        foreach (pending[i]) expected_words.push_back(pending[i]);
    endtask

    // valid stays up across back-to-back words; drop it only for a gap
    task automatic send_word(logic op, logic [7:0] b);
        in_word_t w;
        int g;
        w.op = op;
        w.rx_byte = b;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_word(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (2 * DEPTH * 3 + 20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] v);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PASSTHROUGH: m_pass     = v[0];
            REG_MAX_PAYLOAD: m_maxpl    = v[5:0];
            REG_TIMEOUT:     m_timeout  = v;
            REG_FAILSAFE:    m_failsafe = v;
            REG_ADDR_CTRL:   m_addr_fc  = v[7:0];
            REG_ADDR_TX:     m_addr_tx  = v[7:0];
            REG_CHAN_TYPE:   m_chtype   = v[7:0];
            default: ;
        endcase
    endtask

    // send a frame; a bad frame flips its CRC
    task automatic send_frame(logic [7:0] addr, logic [7:0] typ, int plen, bit good);
        logic [7:0] body [$];
        logic [7:0] c;
        body.push_back(typ);
        for (int i = 0; i < plen; i++) body.push_back(8'($urandom_range(0, 255)));
        c = 8'h00;
        foreach (body[i])
        begin
            c ^= body[i];
            for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
        end
        if (!good) c = ~c;
        send_word(OP_BYTE, addr);
        send_word(OP_BYTE, 8'(plen + 2));
        foreach (body[i]) send_word(OP_BYTE, body[i]);
        send_word(OP_BYTE, c);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_directed();
        send_frame(8'd200, 8'd22, 22, 1'b1);
        send_frame(8'd238, 8'd22, 1, 1'b1);
        send_frame(8'd200, 8'd22, 60, 1'b1);
        send_frame(8'd200, 8'h21, 3, 1'b0);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h02);
        send_word(OP_BYTE, 8'h3F);
        wait_drained();
    endtask

    task automatic test_timeout_failsafe();
        write_reg(REG_TIMEOUT, 16'd1);
        write_reg(REG_FAILSAFE, 16'd3);
        send_frame(8'd200, 8'd22, 2, 1'b1);
        send_word(OP_BYTE, 8'hAA);
        send_word(OP_BYTE, 8'd10);
        send_word(OP_BYTE, 8'h55);
        send_ticks(6);
        wait_drained();
    endtask

    task automatic test_passthrough();
        write_reg(REG_PASSTHROUGH, 16'd1);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h5A);
        send_ticks(3);
        wait_drained();
        write_reg(REG_PASSTHROUGH, 16'd0);
    endtask

    task automatic test_overflow();
        write_reg(REG_MAX_PAYLOAD, 16'd60);
        write_reg(REG_TIMEOUT, 16'd65535);
        send_word(OP_BYTE, 8'h11);
        send_word(OP_BYTE, 8'd62);
        repeat (64) send_word(OP_BYTE, 8'($urandom_range(0, 255)));
        wait_drained();
        write_reg(REG_MAX_PAYLOAD, 16'd0);
        send_word(OP_BYTE, 8'h01);
        send_word(OP_BYTE, 8'h03);
        send_word(OP_BYTE, 8'h22);
        wait_drained();
    endtask

    task automatic random_phase(int items);
        int sent;
        int r;
        int plen;
        int n;
        sent = 0;
        while (sent < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                r = $urandom_range(0, 3);
                plen = $urandom_range(1, (m_maxpl > 8) ? 8 : (m_maxpl == 0 ? 1 : m_maxpl));
                send_frame(r == 0 ? m_addr_fc : r == 1 ? m_addr_tx : 8'($urandom_range(0, 255)),
                           ($urandom_range(0, 1) ? m_chtype : 8'($urandom_range(0, 255))),
                           plen,
                           $urandom_range(0, 5) != 0);
                sent += plen + 4;
            end
            else if (r < 80)
            begin
                send_word(OP_BYTE, 8'($urandom_range(0, 255)));
                sent++;
            end
            else
            begin
                n = $urandom_range(1, 4);
                send_ticks(n);
                sent += n;
            end
        end
        wait_drained();
    endtask

    task automatic test_random();
        write_reg(REG_MAX_PAYLOAD, 16'd8);
        write_reg(REG_TIMEOUT, 16'd3);
        write_reg(REG_FAILSAFE, 16'd6);
        write_reg(REG_ADDR_CTRL, 16'h0000);
        write_reg(REG_ADDR_TX, 16'h00FF);
        write_reg(REG_CHAN_TYPE, 16'h00FF);
        random_phase(60);
        write_reg(REG_MAX_PAYLOAD, 16'd1);
        write_reg(REG_TIMEOUT, 16'd2);
        write_reg(REG_FAILSAFE, 16'd65535);
        write_reg(REG_ADDR_CTRL, 16'd200);
        write_reg(REG_ADDR_TX, 16'd238);
        write_reg(REG_CHAN_TYPE, 16'd22);
        random_phase(50);
        write_reg(REG_MAX_PAYLOAD, 16'd60);
        write_reg(REG_TIMEOUT, 16'd65535);
        write_reg(REG_FAILSAFE, 16'd1);
        random_phase(60);
    endtask

    // out_ready stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 30)
            out_ready <= 1'b1;
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("crsf_frame_receiver: mismatch");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word kind %0d data %02h", out_data.kind, out_data.data);
                    errors++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (out_data.kind != exp_w.kind)
                    begin
                        $error("kind: expected %0d actual %0d", exp_w.kind, out_data.kind);
                        errors++;
                    end
                    if (out_data.data != exp_w.data)
                    begin
                        $error("data: expected %02h actual %02h", exp_w.data, out_data.data);
                        errors++;
                    end
                    if (out_data.frame_end != exp_w.frame_end)
                    begin
                        $error("frame_end: expected %0b actual %0b",
                               exp_w.frame_end, out_data.frame_end);
                        errors++;
                    end
                    if (out_data.link_went_up != exp_w.link_went_up)
                    begin
                        $error("link_went_up: expected %0b actual %0b",
                               exp_w.link_went_up, out_data.link_went_up);
                        errors++;
                    end
                    if (out_data.last != exp_w.last)
                    begin
                        $error("last: expected %0b actual %0b", exp_w.last, out_data.last);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        errors = 0;
        quiet_cycles = 0;
        m_pass = 1'b0;
        m_maxpl = 6'd60;
        m_timeout = 16'd100;
        m_failsafe = 16'd300;
        m_addr_fc = 8'd200;
        m_addr_tx = 8'd238;
        m_chtype = 8'd22;
        fill = 0;
        idle_ms = 16'd0;
        since_ch = 16'd0;
        link_up = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_timeout_failsafe();
        test_passthrough();
        test_overflow();
        test_random();
        wait_drained();
        if (errors == 0 && expected_words.size() == 0)
            $display("crsf_frame_receiver: match");
        else
            $display("crsf_frame_receiver: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/crsf_pkg.sv
rtl/crsf_window_ram.sv
rtl/crsf_out_stage.sv
rtl/crsf_frame_receiver.sv
tb/crsf_frame_receiver_test.sv
